### sv/jpeg_frame_size_scanner_top_assert.svh
// Assertion macros for the JPEG frame size scanner.
`ifndef JPEG_FRAME_SIZE_SCANNER_TOP_ASSERT_SVH
`define JPEG_FRAME_SIZE_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define JFSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define JFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/jfss_pkg.sv
// Types and constants for the JPEG frame size scanner.
package jfss_pkg;

  typedef enum logic [11:0] {
    PH_SOI0   = 12'b0000_0000_0001,
    PH_SOI1   = 12'b0000_0000_0010,
    PH_MARKER = 12'b0000_0000_0100,
    PH_LEN_HI = 12'b0000_0000_1000,
    PH_LEN_LO = 12'b0000_0001_0000,
    PH_SKIP   = 12'b0000_0010_0000,
    PH_PREC   = 12'b0000_0100_0000,
    PH_H_HI   = 12'b0000_1000_0000,
    PH_H_LO   = 12'b0001_0000_0000,
    PH_W_HI   = 12'b0010_0000_0000,
    PH_W_LO   = 12'b0100_0000_0000,
    PH_DONE   = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SOI  = 3'd1,
    ST_ENDED   = 3'd2,
    ST_EOI_SOS = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_ZERO    = 3'd5
  } status_t;

  typedef enum logic {
    REG_MAX_WIDTH  = 1'b0,
    REG_MAX_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [7:0] MK_FILL    = 8'hFF;
  localparam logic [7:0] MK_SOI     = 8'hD8;
  localparam logic [7:0] MK_EOI     = 8'hD9;
  localparam logic [7:0] MK_SOS     = 8'hDA;
  localparam logic [7:0] MK_TEM     = 8'h01;
  localparam logic [7:0] MK_RST0    = 8'hD0;
  localparam logic [7:0] MK_RST7    = 8'hD7;
  localparam logic [7:0] MK_SOF_LO  = 8'hC0;
  localparam logic [7:0] MK_SOF_HI  = 8'hCF;
  localparam logic [7:0] MK_DHT     = 8'hC4;
  localparam logic [7:0] MK_JPG     = 8'hC8;
  localparam logic [7:0] MK_DAC     = 8'hCC;

  localparam logic [15:0] LIMIT_RESET   = 16'd1024;
  localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd8;

  typedef struct packed {
    status_t     status;
    logic [15:0] width;
    logic [15:0] height;
    logic        lim_ok;
  } res_t;

endpackage

### sv/jpeg_frame_size_scanner_top.sv
// JPEG frame size scanner: byte parser, limit check and output buffering.
//
// Usage: feed a JPEG file one byte per request on the in_ channel, then one
// request with in_end_of_file set. The scanner checks SOI, walks the marker
// segments and reports the size from the first frame header on the out_
// channel: status, width, height and a within-limit flag against the
// max_width / max_height registers written over the cfg_ port.
// Each file gives at most one result; an end-of-file request after an
// undecided scan also gives one, and always returns the scanner to start.
// Throughput: one byte per cycle while in_ready is high; the whole parse
// step is one phase update and one 16-bit decrement or compare between
// the phase registers and the result register. A result is registered into
// the output register, or into the skid entry while that register stalls.
// Stall: an output register plus one skid entry hold results; in_ready only
// drops while both hold a result, and bytes keep flowing otherwise.
// Reset (synchronous, rst_n low) empties both result stages, returns the
// parser to expect SOI and sets both limits to 1024.
`include "jpeg_frame_size_scanner_top_assert.svh"

module jpeg_frame_size_scanner_top
  import jfss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic        out_within_limit,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic        fh_r, fh_nxt;
  logic [15:0] hgt_r, hgt_nxt;
  logic [15:0] max_w_r, max_h_r;

  logic        out_valid_r, skid_valid_r;
  res_t        out_r, skid_r;

  logic        in_fire;
  logic        res_valid;
  status_t     res_status;
  logic [15:0] res_w, res_h;
  res_t        res;
  logic [15:0] word;
  logic        is_sof;
  logic        out_load;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign word     = {hold_r, in_data_byte};
  assign is_sof   = (in_data_byte >= MK_SOF_LO) && (in_data_byte <= MK_SOF_HI) &&
                    (in_data_byte != MK_DHT) && (in_data_byte != MK_JPG) &&
                    (in_data_byte != MK_DAC);

  always_comb begin
    phase_nxt  = phase_r;
    hold_nxt   = hold_r;
    skip_nxt   = skip_r;
    fh_nxt     = fh_r;
    hgt_nxt    = hgt_r;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_w      = 16'd0;
    res_h      = 16'd0;
    if (in_fire) begin
      if (in_end_of_file) begin
        if (phase_r == PH_SOI0 || phase_r == PH_SOI1) begin
          res_valid  = 1'b1;
          res_status = ST_NO_SOI;
        end else if (phase_r != PH_DONE) begin
          res_valid  = 1'b1;
          res_status = ST_ENDED;
        end
        phase_nxt = PH_SOI0;
        hold_nxt  = 8'd0;
        skip_nxt  = 16'd0;
        fh_nxt    = 1'b0;
        hgt_nxt   = 16'd0;
      end else begin
        unique case (phase_r)
          PH_SOI0: begin
            if (in_data_byte == MK_FILL) begin
              phase_nxt = PH_SOI1;
            end else begin
              res_valid  = 1'b1;
              res_status = ST_NO_SOI;
              phase_nxt  = PH_DONE;
            end
          end
          PH_SOI1: begin
            if (in_data_byte == MK_SOI) begin
              phase_nxt = PH_MARKER;
            end else begin
              res_valid  = 1'b1;
              res_status = ST_NO_SOI;
              phase_nxt  = PH_DONE;
            end
          end
          PH_MARKER: begin
            if (in_data_byte == MK_FILL) begin
              phase_nxt = PH_MARKER;
            end else if (in_data_byte == MK_EOI || in_data_byte == MK_SOS) begin
              res_valid  = 1'b1;
              res_status = ST_EOI_SOS;
              phase_nxt  = PH_DONE;
            end else if (in_data_byte == MK_TEM ||
                         (in_data_byte >= MK_RST0 && in_data_byte <= MK_RST7)) begin
              phase_nxt = PH_MARKER;
            end else begin
              fh_nxt    = is_sof;
              phase_nxt = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            hold_nxt  = in_data_byte;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (word < MIN_SEG_LEN || (fh_r && word < MIN_FRAME_LEN)) begin
              res_valid  = 1'b1;
              res_status = ST_BAD_LEN;
              phase_nxt  = PH_DONE;
            end else if (fh_r) begin
              phase_nxt = PH_PREC;
            end else begin
              skip_nxt  = word - MIN_SEG_LEN;
              phase_nxt = (word == MIN_SEG_LEN) ? PH_MARKER : PH_SKIP;
            end
          end
          PH_SKIP: begin
            // count is never zero here
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) phase_nxt = PH_MARKER;
          end
          PH_PREC: phase_nxt = PH_H_HI;
          PH_H_HI: begin
            hold_nxt  = in_data_byte;
            phase_nxt = PH_H_LO;
          end
          PH_H_LO: begin
            hgt_nxt   = word;
            phase_nxt = PH_W_HI;
          end
          PH_W_HI: begin
            hold_nxt  = in_data_byte;
            phase_nxt = PH_W_LO;
          end
          PH_W_LO: begin
            res_valid = 1'b1;
            phase_nxt = PH_DONE;
            if (word == 16'd0 || hgt_r == 16'd0) begin
              res_status = ST_ZERO;
            end else begin
              res_status = ST_OK;
              res_w      = word;
              res_h      = hgt_r;
            end
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
    res.status = res_status;
    res.width  = res_w;
    res.height = res_h;
    res.lim_ok = (res_status == ST_OK) && (res_w <= max_w_r) && (res_h <= max_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOI0;
      hold_r  <= 8'd0;
      skip_r  <= 16'd0;
      fh_r    <= 1'b0;
      hgt_r   <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      skip_r  <= skip_nxt;
      fh_r    <= fh_nxt;
      hgt_r   <= hgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_w_r <= LIMIT_RESET;
      max_h_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_WIDTH:  max_w_r <= cfg_wdata;
        REG_MAX_HEIGHT: max_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output register with one skid entry behind it.
  assign out_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_image_width  = out_r.width;
  assign out_image_height = out_r.height;
  assign out_within_limit = out_r.lim_ok;

  `JFSS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                   "skid entry holds a request while output stage is empty")
  `JFSS_ASSERT_NOW(a_fail_zero_size, out_valid_r && out_r.status != ST_OK,
                   out_r.width == 16'd0 && out_r.height == 16'd0 && !out_r.lim_ok,
                   "failed result carries a size or limit flag")
  `JFSS_ASSERT_NOW(a_skip_nonzero, phase_r == PH_SKIP, skip_r != 16'd0,
                   "skip phase entered with zero count")
  `JFSS_ASSERT_NEXT(a_eof_restart, in_fire && in_end_of_file, phase_r == PH_SOI0,
                    "end of file did not restart the parser")
  `JFSS_ASSERT_NEXT(a_no_result_after_done, in_fire && phase_r == PH_DONE && !in_end_of_file,
                    phase_r == PH_DONE, "parser left the done phase without end of file")

endmodule
